>>> src/bcs_pkg.sv
// Shared types and constants for the box contact scan block.
`default_nettype none

package bcs_pkg;

  localparam logic       KIND_WRITE = 1'b0;
  localparam logic       KIND_QUERY = 1'b1;

  localparam logic [1:0] TYPE_NONE  = 2'd0;
  localparam logic [1:0] TYPE_GHOST = 2'd3;

  localparam logic signed [16:0] MARGIN_ONE = 17'sd16;
  localparam logic signed [16:0] MARGIN_TWO = 17'sd32;

  localparam logic [15:0] GAP_NONE = 16'hFFFF;
  localparam logic [7:0]  FALL_MAX = 8'hFF;

  typedef struct packed {
    logic              kind;
    logic [5:0]        slot;
    logic              slot_valid;
    logic signed [15:0] box_x;
    logic signed [15:0] box_y;
    logic [14:0]       box_width;
    logic [14:0]       box_height;
    logic [1:0]        box_type;
    logic [7:0]        box_id;
    logic [7:0]        fall_count;
  } req_t;

  typedef struct packed {
    logic        touch_right;
    logic        touch_left;
    logic        touch_ground;
    logic        touch_top;
    logic [15:0] ground_gap;
    logic        ground_seen;
    logic [7:0]  new_fall_count;
  } rsp_t;

  // One obstacle table word
  typedef struct packed {
    logic        valid;
    logic [1:0]  box_type;
    logic [7:0]  box_id;
    logic [15:0] box_x;
    logic [15:0] box_y;
    logic [14:0] box_width;
    logic [14:0] box_height;
  } entry_t;

  // Controller to datapath commands
  typedef struct packed {
    logic wr_en;
    logic wr_clear;
    logic rd_en;
    logic rd_last;
    logic q_load;
    logic acc_clear;
    logic out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_done;
  } sts_t;

endpackage

`default_nettype wire

>>> src/bcs_datapath.sv
// Obstacle table memory, compare pipeline, contact accumulator and result register.
`default_nettype none

module bcs_datapath
  import bcs_pkg::*;
#(
  parameter int OBSTACLE_SLOTS = 64,
  parameter int AW = 6
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire cmd_t          cmd,
  input  wire logic [AW-1:0] addr,
  input  wire req_t          req,
  output sts_t               sts,
  output rsp_t               rsp
);

  entry_t mem [OBSTACLE_SLOTS];
  entry_t wr_word;
  entry_t rd_r;
  logic   rd_v_r, rd_last_r;

  // Query box, margins folded into the query side
  logic signed [16:0] q_pl_r, q_pb_r, q_pr_r, q_pt_r;
  logic signed [16:0] q_pr_m32_r, q_pl_p32_r, q_pt_m16_r, q_pb_p16_r;
  logic [7:0]         q_id_r, q_fall_r;
  logic signed [16:0] in_pl, in_pb, in_w, in_h;

  // Entry bounds stage
  logic signed [16:0] b_ol_r, b_orr_r, b_ob_r, b_ot_r;
  logic               b_qual_r, b_v_r, b_last_r;
  logic signed [16:0] rd_ol, rd_ob, rd_w, rd_h;
  logic               rd_qual;

  // Compare stage
  logic        c_tr_r, c_tl_r, c_tg_r, c_tt_r, c_bl_r, c_v_r, c_last_r;
  logic [15:0] c_d_r;
  logic        vmid, hin, cmp_tr, cmp_tl, cmp_tg, cmp_tt, cmp_bl;
  logic signed [16:0] cmp_d;

  // Accumulator
  logic        acc_tr_r, acc_tl_r, acc_tg_r, acc_tt_r, acc_below_r;
  logic [15:0] acc_gap_r;
  logic        scan_done_r;
  rsp_t        out_r;

  always_comb begin
    wr_word = '0;
    if (!cmd.wr_clear) begin
      wr_word.valid      = req.slot_valid;
      wr_word.box_type   = req.box_type;
      wr_word.box_id     = req.box_id;
      wr_word.box_x      = req.box_x;
      wr_word.box_y      = req.box_y;
      wr_word.box_width  = req.box_width;
      wr_word.box_height = req.box_height;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[addr] <= wr_word;
    end
    if (cmd.rd_en) begin
      rd_r <= mem[addr];
    end
  end

  assign in_pl = $signed({req.box_x[15], req.box_x});
  assign in_pb = $signed({req.box_y[15], req.box_y});
  assign in_w  = $signed({2'b00, req.box_width});
  assign in_h  = $signed({2'b00, req.box_height});

  always_ff @(posedge clk) begin
    if (cmd.q_load) begin
      q_pl_r     <= in_pl;
      q_pb_r     <= in_pb;
      q_pr_r     <= in_pl + in_w;
      q_pt_r     <= in_pb + in_h;
      q_pr_m32_r <= in_pl + in_w - MARGIN_TWO;
      q_pl_p32_r <= in_pl + MARGIN_TWO;
      q_pt_m16_r <= in_pb + in_h - MARGIN_ONE;
      q_pb_p16_r <= in_pb + MARGIN_ONE;
      q_id_r     <= req.box_id;
      q_fall_r   <= req.fall_count;
    end
  end

  assign rd_ol = $signed({rd_r.box_x[15], rd_r.box_x});
  assign rd_ob = $signed({rd_r.box_y[15], rd_r.box_y});
  assign rd_w  = $signed({2'b00, rd_r.box_width});
  assign rd_h  = $signed({2'b00, rd_r.box_height});
  assign rd_qual = rd_r.valid && (rd_r.box_id != q_id_r) &&
                   (rd_r.box_type != TYPE_NONE) && (rd_r.box_type != TYPE_GHOST);

  always_ff @(posedge clk) begin
    b_ol_r   <= rd_ol;
    b_ob_r   <= rd_ob;
    b_orr_r  <= rd_ol + rd_w;
    b_ot_r   <= rd_ob + rd_h;
    b_qual_r <= rd_qual;
    b_last_r <= rd_last_r;
  end

  always_comb begin
    vmid   = (q_pt_m16_r > b_ob_r) && (q_pb_p16_r < b_ot_r);
    hin    = (q_pr_m32_r > b_ol_r) && (q_pl_p32_r < b_orr_r);
    cmp_tr = (q_pr_r >= b_ol_r) && (q_pr_r <= b_orr_r) && vmid;
    cmp_tl = (q_pl_r >= b_ol_r) && (q_pl_r <= b_orr_r) && vmid;
    cmp_tg = hin && (q_pb_r >= b_ob_r) && (q_pb_r <= b_ot_r);
    cmp_tt = hin && (q_pt_r >= b_ob_r) && (q_pt_r <= b_ot_r);
    // Obstacle below only counts when the top test missed
    cmp_bl = !cmp_tt && (q_pr_r > b_ol_r) && (q_pl_r < b_orr_r) && (q_pb_r > b_ot_r);
    cmp_d  = q_pb_r - b_ot_r;
  end

  always_ff @(posedge clk) begin
    c_tr_r   <= cmp_tr && b_qual_r;
    c_tl_r   <= cmp_tl && b_qual_r;
    c_tg_r   <= cmp_tg && b_qual_r;
    c_tt_r   <= cmp_tt && b_qual_r;
    c_bl_r   <= cmp_bl && b_qual_r;
    c_d_r    <= cmp_d[15:0];
    c_last_r <= b_last_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_v_r      <= 1'b0;
      rd_last_r   <= 1'b0;
      b_v_r       <= 1'b0;
      c_v_r       <= 1'b0;
      scan_done_r <= 1'b0;
    end else begin
      rd_v_r      <= cmd.rd_en;
      rd_last_r   <= cmd.rd_en && cmd.rd_last;
      b_v_r       <= rd_v_r;
      c_v_r       <= b_v_r;
      scan_done_r <= c_v_r && c_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clear) begin
      acc_tr_r    <= 1'b0;
      acc_tl_r    <= 1'b0;
      acc_tg_r    <= 1'b0;
      acc_tt_r    <= 1'b0;
      acc_below_r <= 1'b0;
      acc_gap_r   <= GAP_NONE;
    end else if (c_v_r) begin
      acc_tr_r <= acc_tr_r | c_tr_r;
      acc_tl_r <= acc_tl_r | c_tl_r;
      acc_tg_r <= acc_tg_r | c_tg_r;
      acc_tt_r <= acc_tt_r | c_tt_r;
      if (c_bl_r) begin
        acc_below_r <= 1'b1;
        if (!acc_below_r || (c_d_r < acc_gap_r)) begin
          acc_gap_r <= c_d_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.touch_right  <= acc_tr_r;
      out_r.touch_left   <= acc_tl_r;
      out_r.touch_ground <= acc_tg_r;
      out_r.touch_top    <= acc_tt_r;
      out_r.ground_gap   <= acc_tg_r ? 16'd0 : acc_gap_r;
      out_r.ground_seen  <= acc_tg_r | acc_below_r;
      if (acc_tg_r) begin
        out_r.new_fall_count <= 8'd0;
      end else if (q_fall_r == FALL_MAX) begin
        out_r.new_fall_count <= FALL_MAX;
      end else begin
        out_r.new_fall_count <= q_fall_r + 8'd1;
      end
    end
  end

  assign sts.scan_done = scan_done_r;
  assign rsp           = out_r;

endmodule

`default_nettype wire

>>> src/bcs_ctrl.sv
// Sequencer for table clearing, slot writes, query scans and result handoff.
`default_nettype none

module bcs_ctrl
  import bcs_pkg::*;
#(
  parameter int OBSTACLE_SLOTS = 64,
  parameter int AW = 6
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_kind,
  input  wire logic [5:0]    in_slot,
  output logic               in_stall,
  output logic               out_valid,
  input  wire logic          out_stall,
  input  wire sts_t          sts,
  output cmd_t               cmd,
  output logic [AW-1:0]      addr
);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SCAN  = 5'b00100,
    ST_DRAIN = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  localparam logic [AW-1:0] LAST = AW'(OBSTACLE_SLOTS - 1);

  state_t        state_r, state_nxt;
  logic [AW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [31:0]   slot_ext;
  logic          accept, slot_ok;

  assign slot_ext = 32'(in_slot);
  assign slot_ok  = slot_ext < 32'(OBSTACLE_SLOTS);
  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    addr      = cnt_r;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.wr_en    = 1'b1;
        cmd.wr_clear = 1'b1;
        if (cnt_r == LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_IDLE: begin
        addr = slot_ext[AW-1:0];
        if (accept && (in_kind == KIND_WRITE) && slot_ok) begin
          cmd.wr_en = 1'b1;
        end
        if (accept && (in_kind == KIND_QUERY)) begin
          cmd.q_load    = 1'b1;
          cmd.acc_clear = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.rd_en   = 1'b1;
        cmd.rd_last = (cnt_r == LAST);
        if (cnt_r == LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_DRAIN: begin
        if (sts.scan_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // Hold until the result register is free
        if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_done_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    sts.scan_done |-> (state_r == ST_DRAIN))
    else $error("scan completion outside drain");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr_en && cmd.rd_en))
    else $error("table written during scan");

  a_query_scans: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_kind == KIND_QUERY)) |=> (state_r == ST_SCAN) && (cnt_r == '0))
    else $error("query request did not start a scan");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_DONE))
    else $error("result raised outside done");

endmodule

`default_nettype wire

>>> src/box_contact_scan.sv
// Top level of the box contact scan block: obstacle table with per-query contact scan.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-----------------------------------------
//  in      | in  | in_valid/in_stall  | req_t: slot write or box query
//  out     | out | out_valid/out_stall| rsp_t: contact flags, ground gap, fall count
//
// A slot write is stored in the table in the cycle it is accepted. For a query the
// single-port table is read one slot per cycle, then a four-stage compare
// pipeline drains before the result register loads.
// After reset a clearing pass empties all OBSTACLE_SLOTS table slots;
// in_stall stays high meanwhile.
// A stalled result waits in the output register; the next request is taken
// meanwhile, and a second query holds at its end until that register is free.
`default_nettype none

module box_contact_scan
  import bcs_pkg::*;
#(
  parameter int OBSTACLE_SLOTS = 64
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_stall,
  input  wire req_t in_data,
  output logic      out_valid,
  input  wire logic out_stall,
  output rsp_t      out_data
);

  localparam int AW = (OBSTACLE_SLOTS > 1) ? $clog2(OBSTACLE_SLOTS) : 1;

  cmd_t          cmd;
  sts_t          sts;
  logic [AW-1:0] addr;

  bcs_ctrl #(
    .OBSTACLE_SLOTS(OBSTACLE_SLOTS),
    .AW            (AW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_data.kind),
    .in_slot  (in_data.slot),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sts      (sts),
    .cmd      (cmd),
    .addr     (addr)
  );

  bcs_datapath #(
    .OBSTACLE_SLOTS(OBSTACLE_SLOTS),
    .AW            (AW)
  ) u_datapath (
    .clk  (clk),
    .rst_n(rst_n),
    .cmd  (cmd),
    .addr (addr),
    .req  (in_data),
    .sts  (sts),
    .rsp  (out_data)
  );

endmodule

`default_nettype wire

>>> verif/tb_box_contact_scan.sv
// Self-checking testbench for box_contact_scan: obstacle table writes and contact queries.
`default_nettype none

module tb_box_contact_scan;
  import bcs_pkg::*;

  localparam int SLOTS       = 64;
  localparam int EDGE_MARGIN = 16;
  localparam int SIDE_MARGIN = 32;
  localparam int RANDOM_REQS = 1150;
  localparam int PHASE_LEN   = 250;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int DRAIN_WAIT  = SLOTS + 40;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_data;

  // obstacle table as the block should hold it
  bit          tab_valid [SLOTS];
  logic [15:0] tab_x     [SLOTS];
  logic [15:0] tab_y     [SLOTS];
  logic [14:0] tab_w     [SLOTS];
  logic [14:0] tab_h     [SLOTS];
  logic [1:0]  tab_type  [SLOTS];
  logic [7:0]  tab_id    [SLOTS];

  req_t pending_reqs [$];
  rsp_t expected_contacts [$];
  int   errors = 0;
  int   accepted = 0;
  int   cycles = 0;
  int   traffic_phase = 0;

  always #5 clk = ~clk;

  box_contact_scan #(.OBSTACLE_SLOTS(SLOTS)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  function automatic bit roll(int pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic int rnd_span(int lo, int hi);
    return lo + int'($urandom_range(hi - lo));
  endfunction

  // land on the 16-unit grid half the time so edges meet exactly
  function automatic int snap(int v);
    return roll(50) ? (v & ~15) : v;
  endfunction

  function automatic rsp_t predict_contact(req_t q);
    int   pl, pb, pr, pt, obs_l, obs_b, obs_r, obs_t, gap_d;
    logic vmid, hin, below, tr, tl, tg, tt;
    int   gap;
    rsp_t r;
    pl = $signed(q.box_x);
    pb = $signed(q.box_y);
    pr = pl + int'(q.box_width);
    pt = pb + int'(q.box_height);
    {tr, tl, tg, tt, below} = '0;
    gap = int'(GAP_NONE);
    for (int i = 0; i < SLOTS; i++) begin
      if (!tab_valid[i] || tab_id[i] == q.box_id ||
          tab_type[i] == TYPE_NONE || tab_type[i] == TYPE_GHOST) continue;
      obs_l = $signed(tab_x[i]);
      obs_b = $signed(tab_y[i]);
      obs_r = obs_l + int'(tab_w[i]);
      obs_t = obs_b + int'(tab_h[i]);
      vmid = (pt > obs_b + EDGE_MARGIN) && (pb < obs_t - EDGE_MARGIN);
      if (pr >= obs_l && pr <= obs_r && vmid) tr = 1'b1;
      if (pl >= obs_l && pl <= obs_r && vmid) tl = 1'b1;
      hin = (pr - SIDE_MARGIN > obs_l) && (pl < obs_r - SIDE_MARGIN);
      if (hin && pb >= obs_b && pb <= obs_t) tg = 1'b1;
      if (hin && pt >= obs_b && pt <= obs_t) begin
        tt = 1'b1;
      end else if (pr > obs_l && pl < obs_r && pb > obs_t) begin
        gap_d = pb - obs_t;
        if (!below || gap_d < gap) gap = gap_d;
        below = 1'b1;
      end
    end
    if (tg) gap = 0;
    r.touch_right    = tr;
    r.touch_left     = tl;
    r.touch_ground   = tg;
    r.touch_top      = tt;
    r.ground_gap     = gap[15:0];
    r.ground_seen    = tg | below;
    r.new_fall_count = tg ? 8'd0 : (q.fall_count < FALL_MAX ? q.fall_count + 8'd1 : FALL_MAX);
    return r;
  endfunction

  function automatic void apply_request(req_t q);
    if (q.kind == KIND_WRITE) begin
      if (q.slot_valid) begin
        tab_valid[q.slot] = 1'b1;
        tab_x[q.slot]     = q.box_x;
        tab_y[q.slot]     = q.box_y;
        tab_w[q.slot]     = q.box_width;
        tab_h[q.slot]     = q.box_height;
        tab_type[q.slot]  = q.box_type;
        tab_id[q.slot]    = q.box_id;
      end else begin
        // leave stored fields as they are
        tab_valid[q.slot] = 1'b0;
      end
    end else begin
      expected_contacts.push_back(predict_contact(q));
    end
  endfunction

  function automatic req_t noise_req();
    bit [95:0] raw;
    raw = {$urandom(), $urandom(), $urandom()};
    return raw[87:0];
  endfunction

  function automatic req_t mk_fill(int slot, int x, int y, int w, int h, int ty, int id);
    req_t r;
    r = noise_req();
    r.kind       = KIND_WRITE;
    r.slot       = slot[5:0];
    r.slot_valid = 1'b1;
    r.box_x      = x[15:0];
    r.box_y      = y[15:0];
    r.box_width  = w[14:0];
    r.box_height = h[14:0];
    r.box_type   = ty[1:0];
    r.box_id     = id[7:0];
    return r;
  endfunction

  function automatic req_t mk_clear(int slot);
    req_t r;
    r = noise_req();
    r.kind       = KIND_WRITE;
    r.slot       = slot[5:0];
    r.slot_valid = 1'b0;
    return r;
  endfunction

  function automatic req_t mk_query(int x, int y, int w, int h, int id, int fall);
    req_t r;
    r = noise_req();
    r.kind       = KIND_QUERY;
    r.box_x      = x[15:0];
    r.box_y      = y[15:0];
    r.box_width  = w[14:0];
    r.box_height = h[14:0];
    r.box_id     = id[7:0];
    r.fall_count = fall[7:0];
    return r;
  endfunction

  function automatic int scene_id();
    return roll(80) ? rnd_span(1, 6) : int'($urandom_range(255));
  endfunction

  task automatic report_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // request side
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_request(in_data);
        accepted++;
      end
      traffic_phase <= (accepted / PHASE_LEN) % 5;
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() > 0 &&
            !roll(traffic_phase == 1 ? 83 : traffic_phase == 3 ? 23 : 0)) begin
          in_valid <= 1'b1;
          in_data  <= pending_reqs.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side
  always @(posedge clk) begin
    rsp_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid === 1'b1 && !out_stall) begin
        if (expected_contacts.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %p", $time, out_data);
          errors++;
        end else begin
          want = expected_contacts.pop_front();
          report_field("touch_right", want.touch_right, out_data.touch_right);
          report_field("touch_left", want.touch_left, out_data.touch_left);
          report_field("touch_ground", want.touch_ground, out_data.touch_ground);
          report_field("touch_top", want.touch_top, out_data.touch_top);
          report_field("ground_gap", want.ground_gap, out_data.ground_gap);
          report_field("ground_seen", want.ground_seen, out_data.ground_seen);
          report_field("new_fall_count", want.new_fall_count, out_data.new_fall_count);
        end
      end
      out_stall <= roll(traffic_phase == 2 ? 83 : traffic_phase == 3 ? 23 : 0);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int n_random;
    int cx, cy, x, y;
    n_random = 0;
    cx = 0;
    cy = 0;

    // directed: empty table, saturating fall count
    pending_reqs.push_back(mk_query(0, 0, 160, 160, 1, 255));
    pending_reqs.push_back(mk_fill(0, 0, 0, 1600, 160, 1, 10));
    pending_reqs.push_back(mk_query(320, 160, 160, 160, 1, 7));     // resting on floor
    pending_reqs.push_back(mk_query(320, 160, 160, 160, 10, 7));    // own id skipped
    pending_reqs.push_back(mk_query(320, 480, 160, 160, 1, 0));     // gap below
    pending_reqs.push_back(mk_fill(1, 800, 160, 160, 800, 2, 11));
    pending_reqs.push_back(mk_query(640, 320, 160, 160, 1, 3));     // right edge on wall
    pending_reqs.push_back(mk_query(960, 320, 160, 160, 1, 3));     // left edge on wall
    pending_reqs.push_back(mk_fill(2, 0, 1600, 1600, 160, 1, 12));
    pending_reqs.push_back(mk_query(320, 1440, 160, 160, 2, 40));   // head on ceiling
    pending_reqs.push_back(mk_fill(3, 3200, 0, 320, 160, 0, 13));
    pending_reqs.push_back(mk_fill(4, 3200, 0, 320, 160, 3, 14));
    pending_reqs.push_back(mk_query(3200, 160, 160, 160, 1, 9));    // only non-colliding types
    pending_reqs.push_back(mk_clear(0));
    pending_reqs.push_back(mk_query(320, 160, 160, 160, 1, 7));     // floor gone
    pending_reqs.push_back(mk_fill(63, -32768, -32768, 32767, 0, 2, 255));
    pending_reqs.push_back(mk_query(-32768, 32767, 32767, 32767, 0, 0)); // widest real gap
    pending_reqs.push_back(mk_query(32767, 32767, 32767, 32767, 0, 254));
    pending_reqs.push_back(mk_fill(5, 32767, 32767, 32767, 32767, 2, 200));
    pending_reqs.push_back(mk_query(32767, 32767, 32767, 32767, 0, 128));
    pending_reqs.push_back(mk_query(-32768, -32768, 0, 0, 255, 255));

    // random: build scenes around a moving center, sprinkle noise
    while (n_random < RANDOM_REQS) begin
      if (n_random % 150 == 0) begin
        cx = rnd_span(-28000, 28000);
        cy = rnd_span(-28000, 28000);
        for (int i = 0; i < 8; i++) begin
          pending_reqs.push_back(mk_fill($urandom_range(SLOTS - 1),
              snap(cx + rnd_span(-800, 800)), snap(cy + rnd_span(-800, 800)),
              snap(rnd_span(0, 960)), snap(rnd_span(0, 960)), rnd_span(1, 2), scene_id()));
          n_random++;
        end
      end
      x = snap(cx + rnd_span(-1200, 1200));
      y = snap(cy + rnd_span(-1200, 1200));
      case ($urandom_range(99)) inside
        [0:34]: pending_reqs.push_back(mk_fill($urandom_range(SLOTS - 1), x, y,
                  snap(rnd_span(0, 960)), snap(rnd_span(0, 960)),
                  $urandom_range(3), scene_id()));
        [35:44]: pending_reqs.push_back(mk_clear($urandom_range(SLOTS - 1)));
        [45:89]: pending_reqs.push_back(mk_query(x, y,
                   roll(5) ? 0 : snap(rnd_span(16, 640)), roll(5) ? 0 : snap(rnd_span(16, 640)),
                   scene_id(), roll(20) ? rnd_span(250, 255) : int'($urandom_range(255))));
        default: pending_reqs.push_back(noise_req());
      endcase
      n_random++;
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (pending_reqs.size() != 0 || in_valid);
    while (expected_contacts.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
